### rtl/afl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_pkg - shared types and constants
// Widths, fixed-point constants and register map of the adaptive first-order
// low-pass unit.
// ----------------------------------------------------------------------------
package afl_pkg;

   // Datapath widths
   localparam int SAMPLE_BITS    = 12;
   localparam int COEF_FRAC_BITS = 16;
   localparam int OUT_FRAC_BITS  = 4;
   localparam int RUN_BITS       = 8;
   localparam int COEF_BITS      = COEF_FRAC_BITS + 1;
   localparam int ACCUM_BITS     = SAMPLE_BITS + COEF_FRAC_BITS;
   localparam int OUT_BITS       = SAMPLE_BITS + OUT_FRAC_BITS;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

   // Register port
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [COEF_BITS-1:0]   coef_type;
   typedef logic [ACCUM_BITS-1:0]  accum_type;
   typedef logic [OUT_BITS-1:0]    out_type;
   typedef logic [RUN_BITS-1:0]    run_type;

   // Coefficient constants (Q1.COEF_FRAC_BITS)
   localparam int       COEF_ONE_INT   = 1 << COEF_FRAC_BITS;
   localparam int       COEF_STEP_INT  = (COEF_ONE_INT + 5) / 10;
   localparam int       COEF_START_INT = 56539;
   localparam coef_type COEF_ONE       = coef_type'(COEF_ONE_INT);
   localparam coef_type COEF_STEP      = coef_type'(COEF_STEP_INT);
   localparam coef_type COEF_RESET     = (COEF_START_INT > COEF_ONE_INT) ?
                                         COEF_ONE : coef_type'(COEF_START_INT);

   // Register indexes (byte address / 4)
   localparam logic [CSR_INDEX_BITS-1:0] REG_ADAPT_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_COEF   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FALLBACK     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CHANGE_THR   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_THR      = 3'd4;

   // Direction class of a sample against the previous raw sample
   typedef enum logic [1:0] {
      DIR_FLAT = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   // Configuration seen by the adaptation logic
   typedef struct packed {
      logic       adapt_enable;
      coef_type   fallback_coef;
      sample_type change_thr;
      run_type    run_thr;
      logic       start_load;
      coef_type   start_value;
   } cfg_type;

   // Saturate a written coefficient at 1.0
   function automatic coef_type clamp_coef(input coef_type v);
      return (v > COEF_ONE) ? COEF_ONE : v;
   endfunction

endpackage

### rtl/adaptive_first_order_lowpass_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_first_order_lowpass_unit - adaptive first-order low-pass filter
// One raw sample in, one filtered Q12.4 value out; the coefficient adapts to
// same-direction runs of the input when enabled.
//
//   channel  direction  handshake              payload
//   req_     in         req_tvalid/req_tready  req_tdata[11:0] sample
//   rsp_     out        rsp_tvalid/rsp_tready  rsp_tdata[15:0] filtered
//   csr_     in         APB psel/penable       5 registers at byte addr 4*i
//
// One sample per cycle sustained while rsp_ is not stalled; rsp_tvalid rises once
// the sample from req_ has passed the input register, then the result register.
// The filter state update is combinational between the input register and the
// result register: compare, coefficient step and two multiplies.
// Synchronous active-high reset; no clearing pass, ready right after reset.
// A stall on rsp_ holds the result; req_ keeps accepting until both the
// input and the result registers are full.
// ----------------------------------------------------------------------------
module adaptive_first_order_lowpass_unit (
   input  logic                                clock,
   input  logic                                reset,
   // input samples
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [afl_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [11:0] sample
   // filtered results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [afl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // [15:0] filtered
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [afl_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [afl_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [afl_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import afl_pkg::*;

   logic       in_vld_ff, in_vld_in;
   sample_type sample_ff;
   logic       out_vld_ff, out_vld_in;
   logic       fire;
   logic       req_xfer;
   cfg_type    cfg;
   coef_type   coef;
   out_type    filtered;

   // Stage control: the input register advances when the result slot frees
   assign fire       = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | fire;
   assign req_xfer   = req_tvalid & req_tready;
   assign in_vld_in  = req_xfer | (in_vld_ff & ~fire);
   assign out_vld_in = fire | (out_vld_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         sample_ff <= req_tdata[SAMPLE_BITS-1:0];
      end
   end

   afl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   afl_adapt u_adapt (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .sample (sample_ff),
      .cfg    (cfg),
      .coef   (coef)
   );

   afl_filter u_filter (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .sample   (sample_ff),
      .coef     (coef),
      .filtered (filtered)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(filtered);

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A sample leaving the input register always lands in the result slot
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed sample produced no result");

   // An accepted sample is held in the input register on the next cycle
   a_accept_loads_input: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_vld_ff)
      else $error("accepted sample was lost");

   // The coefficient in use never exceeds 1.0
   a_coef_range: assert property (@(posedge clock) disable iff (reset)
      coef <= COEF_ONE)
      else $error("coefficient above one");

   // A full input register with a stalled result blocks new transfers
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && out_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages full");

endmodule

### rtl/afl_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_csr - configuration registers
// APB-style register file; a start coefficient write also reloads the live
// coefficient through start_load.
// ----------------------------------------------------------------------------
module afl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [afl_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [afl_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [afl_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output afl_pkg::cfg_type                    cfg
);
   import afl_pkg::*;

   logic                      adapt_enable_ff, adapt_enable_in;
   coef_type                  start_coef_ff, start_coef_in;
   coef_type                  fallback_ff, fallback_in;
   sample_type                change_thr_ff, change_thr_in;
   run_type                   run_thr_ff, run_thr_in;
   logic                      wr_en;
   logic [CSR_INDEX_BITS-1:0] index;
   coef_type                  wr_coef;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_INDEX_BITS+1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_coef    = clamp_coef(csr_pwdata[COEF_BITS-1:0]);

   // Write decode
   always_comb begin
      adapt_enable_in = adapt_enable_ff;
      start_coef_in   = start_coef_ff;
      fallback_in     = fallback_ff;
      change_thr_in   = change_thr_ff;
      run_thr_in      = run_thr_ff;
      if (wr_en) begin
         if (index == REG_ADAPT_ENABLE) adapt_enable_in = csr_pwdata[0];
         if (index == REG_START_COEF)   start_coef_in   = wr_coef;
         if (index == REG_FALLBACK)     fallback_in     = wr_coef;
         if (index == REG_CHANGE_THR)   change_thr_in   = csr_pwdata[SAMPLE_BITS-1:0];
         if (index == REG_RUN_THR)      run_thr_in      = csr_pwdata[RUN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adapt_enable_ff <= 1'b0;
         start_coef_ff   <= COEF_RESET;
         fallback_ff     <= '0;
         change_thr_ff   <= '0;
         run_thr_ff      <= '0;
      end else begin
         adapt_enable_ff <= adapt_enable_in;
         start_coef_ff   <= start_coef_in;
         fallback_ff     <= fallback_in;
         change_thr_ff   <= change_thr_in;
         run_thr_ff      <= run_thr_in;
      end
   end

   // Readback
   always_comb begin
      csr_prdata = '0;
      if (index == REG_ADAPT_ENABLE) csr_prdata = CSR_DATA_BITS'(adapt_enable_ff);
      if (index == REG_START_COEF)   csr_prdata = CSR_DATA_BITS'(start_coef_ff);
      if (index == REG_FALLBACK)     csr_prdata = CSR_DATA_BITS'(fallback_ff);
      if (index == REG_CHANGE_THR)   csr_prdata = CSR_DATA_BITS'(change_thr_ff);
      if (index == REG_RUN_THR)      csr_prdata = CSR_DATA_BITS'(run_thr_ff);
   end

   assign cfg.adapt_enable  = adapt_enable_ff;
   assign cfg.fallback_coef = fallback_ff;
   assign cfg.change_thr    = change_thr_ff;
   assign cfg.run_thr       = run_thr_ff;
   assign cfg.start_load    = wr_en && (index == REG_START_COEF);
   assign cfg.start_value   = wr_coef;

endmodule

### rtl/afl_adapt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_adapt - coefficient adaptation
// Classes each sample as up, down or flat, tracks same-class runs and gives
// the coefficient to use for the current sample.
// ----------------------------------------------------------------------------
module afl_adapt (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  afl_pkg::sample_type sample,
   input  afl_pkg::cfg_type    cfg,
   output afl_pkg::coef_type   coef
);
   import afl_pkg::*;

   coef_type   coef_ff, coef_in;
   sample_type prev_raw_ff, prev_raw_in;
   run_type    run_ff, run_in;
   dir_type    dir_ff, dir_in;

   logic [SAMPLE_BITS:0] prev_plus_thr;
   logic [SAMPLE_BITS:0] x_plus_thr;
   dir_type              dir;
   logic                 same;
   logic [RUN_BITS:0]    run_next;
   logic                 rise;
   logic [COEF_BITS:0]   coef_sum;
   coef_type             coef_rise;
   coef_type             coef_adapt;
   logic                 step;

   // Direction class
   assign prev_plus_thr = {1'b0, prev_raw_ff} + {1'b0, cfg.change_thr};
   assign x_plus_thr    = {1'b0, sample} + {1'b0, cfg.change_thr};

   always_comb begin
      priority if ({1'b0, sample} > prev_plus_thr) dir = DIR_UP;
      else if (x_plus_thr < {1'b0, prev_raw_ff})   dir = DIR_DOWN;
      else                                         dir = DIR_FLAT;
   end

   // Run counter and coefficient rise
   assign same      = (dir == dir_ff);
   assign run_next  = {1'b0, run_ff} + (RUN_BITS+1)'(1);
   assign rise      = run_next >= {1'b0, cfg.run_thr};
   assign coef_sum  = {1'b0, coef_ff} + {1'b0, COEF_STEP};
   assign coef_rise = (coef_sum > {1'b0, COEF_ONE}) ? COEF_ONE : coef_sum[COEF_BITS-1:0];

   always_comb begin
      if (!same)     coef_adapt = cfg.fallback_coef;
      else if (rise) coef_adapt = coef_rise;
      else           coef_adapt = coef_ff;
   end

   assign coef = cfg.adapt_enable ? coef_adapt : coef_ff;
   assign step = fire & cfg.adapt_enable;

   // State update; a start coefficient write takes over the coefficient
   always_comb begin
      coef_in     = coef_ff;
      prev_raw_in = prev_raw_ff;
      run_in      = run_ff;
      dir_in      = dir_ff;
      if (step) begin
         coef_in     = coef_adapt;
         prev_raw_in = sample;
         dir_in      = dir;
         if (same) run_in = rise ? cfg.run_thr : run_next[RUN_BITS-1:0];
      end
      if (cfg.start_load) coef_in = cfg.start_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff     <= COEF_RESET;
         prev_raw_ff <= '0;
         run_ff      <= '0;
         dir_ff      <= DIR_FLAT;
      end else begin
         coef_ff     <= coef_in;
         prev_raw_ff <= prev_raw_in;
         run_ff      <= run_in;
         dir_ff      <= dir_in;
      end
   end

endmodule

### rtl/afl_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afl_filter - first-order IIR datapath
// y = K*x + ((1-K)*y_prev >> frac); holds the Q12.16 accumulator and the
// Q12.4 result register.
// ----------------------------------------------------------------------------
module afl_filter (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  afl_pkg::sample_type sample,
   input  afl_pkg::coef_type   coef,
   output afl_pkg::out_type    filtered
);
   import afl_pkg::*;

   localparam int HOLD_PROD_BITS = COEF_BITS + ACCUM_BITS;
   localparam int NEW_PROD_BITS  = COEF_BITS + SAMPLE_BITS;
   localparam int SUM_BITS       = ACCUM_BITS + 2;

   accum_type accum_ff, accum_in;
   out_type   filtered_ff;

   coef_type                  rest;
   logic [HOLD_PROD_BITS-1:0] hold_prod;
   logic [NEW_PROD_BITS-1:0]  new_prod;
   logic [SUM_BITS-1:0]       sum;

   // Two independent products, then one add
   assign rest      = COEF_ONE - coef;
   assign hold_prod = HOLD_PROD_BITS'(rest) * HOLD_PROD_BITS'(accum_ff);
   assign new_prod  = NEW_PROD_BITS'(coef) * NEW_PROD_BITS'(sample);
   assign sum       = SUM_BITS'(new_prod)
                    + SUM_BITS'(hold_prod[HOLD_PROD_BITS-1:COEF_FRAC_BITS]);
   assign accum_in  = sum[ACCUM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff <= '0;
      end else if (fire) begin
         accum_ff <= accum_in;
      end
   end

   // Result register, Q12.4 taken from the top of the new accumulator
   always_ff @(posedge clock) begin
      if (fire) begin
         filtered_ff <= accum_in[ACCUM_BITS-1 -: OUT_BITS];
      end
   end

   assign filtered = filtered_ff;

endmodule

### tb/lowpass_result_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowpass_result_check - result checker for the adaptive low-pass unit
// Watches the register port and both stream channels. Every sample transfer
// runs through a local model of the adaptive filter, and the predicted value
// is queued. Every result transfer is compared with the oldest prediction.
// Mismatches are printed and counted for the testbench top.
// ----------------------------------------------------------------------------
module lowpass_result_check
   import afl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,    // [11:0] sample
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,    // [15:0] filtered
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       fail_count,
   output int                       pending_results
);

   // register copies
   logic       adapt_en;
   coef_type   start_coef;
   coef_type   fallback_coef;
   sample_type change_thr;
   run_type    run_thr;

   // filter state
   coef_type   coef;
   sample_type last_sample;
   accum_type  accum;
   run_type    run_count;
   dir_type    last_dir;

   out_type    expected_filtered[$];
   int         result_index;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      result_index    = 0;
   end

   // Written coefficients are cut to 17 bits and saturate at one
   function automatic coef_type limit_coef(input logic [CSR_DATA_BITS-1:0] value);
      return (value[COEF_BITS-1:0] > COEF_ONE) ? COEF_ONE : value[COEF_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic apply_write(input logic [CSR_ADDR_BITS-1:0] addr,
                              input logic [CSR_DATA_BITS-1:0] value);
      case (addr[CSR_ADDR_BITS-1:2])
         REG_ADAPT_ENABLE: adapt_en = value[0];
         REG_START_COEF: begin
            start_coef = limit_coef(value);
            coef       = start_coef;
         end
         REG_FALLBACK:   fallback_coef = limit_coef(value);
         REG_CHANGE_THR: change_thr = value[SAMPLE_BITS-1:0];
         REG_RUN_THR:    run_thr = value[RUN_BITS-1:0];
         default: ;
      endcase
   endtask

   // One filter step: adapt K (if enabled), then y = K*x + (1-K)*y_prev
   task automatic predict_filtered(input sample_type x, output out_type y);
      logic [SAMPLE_BITS:0] upper_bound;
      logic [SAMPLE_BITS:0] lower_sum;
      dir_type              dir;
      logic [RUN_BITS:0]    next_run;
      logic [COEF_BITS:0]   raised;
      coef_type             rest;
      logic [63:0]          sum;
      if (adapt_en) begin
         upper_bound = {1'b0, last_sample} + change_thr;
         lower_sum   = {1'b0, x} + change_thr;
         if ({1'b0, x} > upper_bound)
            dir = DIR_UP;
         else if (lower_sum < {1'b0, last_sample})
            dir = DIR_DOWN;
         else
            dir = DIR_FLAT;
         last_sample = x;
         if (dir == last_dir) begin
            next_run = {1'b0, run_count} + 1'b1;
            if (next_run >= {1'b0, run_thr}) begin
               raised    = {1'b0, coef} + COEF_STEP;
               coef      = (raised > COEF_ONE) ? COEF_ONE : raised[COEF_BITS-1:0];
               run_count = run_thr;
            end else begin
               run_count = next_run[RUN_BITS-1:0];
            end
         end else begin
            coef = fallback_coef;
         end
         last_dir = dir;
      end
      rest  = COEF_ONE - coef;
      sum   = 64'(coef) * 64'(x)
            + 64'(rest) * 64'(accum[ACCUM_BITS-1:COEF_FRAC_BITS])
            + ((64'(rest) * 64'(accum[COEF_FRAC_BITS-1:0])) >> COEF_FRAC_BITS);
      accum = sum[ACCUM_BITS-1:0];
      y     = accum[ACCUM_BITS-1:COEF_FRAC_BITS-OUT_FRAC_BITS];
   endtask

   // Channel monitor: config writes, result compare, then sample prediction
   always @(posedge clock) begin : watch
      out_type predicted;
      out_type oldest;
      if (reset) begin
         adapt_en      = 1'b0;
         start_coef    = COEF_RESET;
         fallback_coef = '0;
         change_thr    = '0;
         run_thr       = '0;
         coef          = COEF_RESET;
         last_sample   = '0;
         accum         = '0;
         run_count     = '0;
         last_dir      = DIR_FLAT;
         expected_filtered.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            apply_write(csr_paddr, csr_pwdata);
         // compare before queuing: a sample never comes out in its own cycle
         if (rsp_tvalid && rsp_tready) begin
            if (expected_filtered.size() == 0) begin
               report_mismatch($sformatf("result %0d (filtered %h) with none expected",
                                         result_index, rsp_tdata[OUT_BITS-1:0]));
            end else begin
               oldest = expected_filtered.pop_front();
               if (rsp_tdata[OUT_BITS-1:0] !== oldest)
                  report_mismatch($sformatf("result %0d filtered got %h, expected %h",
                                            result_index, rsp_tdata[OUT_BITS-1:0],
                                            oldest));
            end
            result_index++;
         end
         if (req_tvalid && req_tready) begin
            predict_filtered(req_tdata[SAMPLE_BITS-1:0], predicted);
            expected_filtered.push_back(predicted);
         end
      end
      pending_results = expected_filtered.size();
   end

endmodule

### tb/tb_adaptive_first_order_lowpass_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_first_order_lowpass_unit - testbench top
// Drives samples and register writes into the adaptive low-pass unit: a short
// directed part over fixed and adaptive mode, then shaped random sample runs
// (ramps, plateaus and noise) under several register settings and idle
// patterns. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_adaptive_first_order_lowpass_unit;
   import afl_pkg::*;

   localparam int                        STALL_LIMIT  = 2000;
   localparam int                        LONG_HOLD    = 300;
   localparam int                        DRAIN_CYCLES = 8;
   localparam int                        PHASES       = 8;
   localparam int                        PHASE_HALF   = 105;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LAST_IDX = 3'd7;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;    // [11:0] sample
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;           // [15:0] filtered
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int   fail_count;
   int   pending_results;
   int   send_idle_pct   = 0;
   int   stall_pct       = 0;
   int   cur_change_thr  = 0;
   logic hold_request    = 1'b0;
   int   hold_left       = 0;
   int   quiet_cycles    = 0;

   adaptive_first_order_lowpass_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lowpass_result_check result_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: ends the run after too many cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // APB write: setup cycle, then access until pready
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_CHANGE_THR)
         cur_change_thr = int'(value[SAMPLE_BITS-1:0]);
   endtask

   task automatic configure(input logic adapt, input int start, input int fallback,
                            input int change, input int run_len);
      csr_write(REG_ADAPT_ENABLE, CSR_DATA_BITS'(adapt));
      csr_write(REG_START_COEF,   CSR_DATA_BITS'(start));
      csr_write(REG_FALLBACK,     CSR_DATA_BITS'(fallback));
      csr_write(REG_CHANGE_THR,   CSR_DATA_BITS'(change));
      csr_write(REG_RUN_THR,      CSR_DATA_BITS'(run_len));
   endtask

   // One sample transfer, with a random idle gap in front
   task automatic send_sample(input sample_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS-SAMPLE_BITS){1'b0}}, s};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait for every queued result; the count is sampled
   // mid-cycle, after the checker has seen the last edge
   task automatic await_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
   endtask

   // Random segments: rising and falling ramps past the threshold, plateaus
   // inside it, and some noise
   task automatic send_shaped(input int count);
      int sent;
      int seg_len;
      int kind;
      int jitter;
      int level;
      int i;
      sent  = 0;
      level = $urandom_range(4095);
      while (sent < count) begin
         kind    = $urandom_range(99);
         seg_len = $urandom_range(1, 30);
         jitter  = (cur_change_thr < 40) ? cur_change_thr : 40;
         for (i = 0; i < seg_len && sent < count; i++) begin
            if (kind < 15)
               level = $urandom_range(4095);
            else if (kind < 45)
               level = level + cur_change_thr + 1 + int'($urandom_range(20));
            else if (kind < 75)
               level = level - cur_change_thr - 1 - int'($urandom_range(20));
            else
               level = level + int'($urandom_range(2 * jitter)) - jitter;
            if (level < 0)
               level = 0;
            else if (level > 4095)
               level = 4095;
            send_sample(sample_type'(level));
            sent++;
         end
      end
   endtask

   initial begin
      int phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fixed mode at reset settings, full-scale swings
      send_sample(12'hFFF);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'hAAA);
      send_sample(12'h555);
      send_sample(12'h000);
      await_results();

      // adaptive, K at one, zero thresholds: rise on every equal class
      configure(1'b1, 65536, 0, 0, 0);
      send_sample(12'd100);
      send_sample(12'd200);
      send_sample(12'd300);
      send_sample(12'd300);
      send_sample(12'd300);
      send_sample(12'd200);
      send_sample(12'd100);
      send_sample(12'd0);
      send_sample(12'd0);
      await_results();

      // coefficients above one saturate; widest thresholds; unmapped writes
      configure(1'b1, 32'h1FFFF, 32'h1FFFF, 4095, 255);
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      csr_write(REG_LAST_IDX, 32'h0000_0000);
      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'h000);
      await_results();
      // lowered run threshold pulls the counter down
      csr_write(REG_START_COEF, 32'd1000);
      csr_write(REG_RUN_THR, 32'd2);
      send_sample(12'hFFF);
      send_sample(12'h000);
      await_results();

      // random phases over settings and idle patterns
      for (phase = 0; phase < PHASES; phase++) begin
         await_results();
         case (phase)
            3:       configure(1'b0, $urandom_range(131071), $urandom_range(131071),
                               $urandom_range(4095), $urandom_range(255));
            4, 6:    configure(1'b1, $urandom_range(131071), $urandom_range(131071),
                               $urandom_range(4095), $urandom_range(255));
            5:       configure(1'b1, 0, 65536, 0, 255);
            7:       configure(1'b1, 65536, 0, 4095, 1);
            default: configure(1'b1, $urandom_range(131071), $urandom_range(131071),
                               $urandom_range(32), $urandom_range(8));
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 65; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 65; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         // result side holds off while samples keep coming
         if (phase == 0 || phase == 4)
            hold_request <= 1'b1;
         send_shaped(PHASE_HALF);
         // sample side pauses until everything is out
         if (phase == 2 || phase == 6)
            await_results();
         send_shaped(PHASE_HALF);
      end

      await_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
rtl/afl_pkg.sv
rtl/afl_csr.sv
rtl/afl_adapt.sv
rtl/afl_filter.sv
rtl/adaptive_first_order_lowpass_unit.sv
tb/lowpass_result_check.sv
tb/tb_adaptive_first_order_lowpass_unit.sv
